FILE: hdl/rbrc_pkg.sv
`default_nettype none

package rbrc_pkg;

    // Command codes.
    localparam logic [2:0] CMD_BEGIN_WRITE = 3'd0;
    localparam logic [2:0] CMD_END_WRITE   = 3'd1;
    localparam logic [2:0] CMD_BEGIN_READ  = 3'd2;
    localparam logic [2:0] CMD_END_READ    = 3'd3;
    localparam logic [2:0] CMD_CLEAR       = 3'd4;
    localparam logic [2:0] CMD_DISCARD     = 3'd5;
    localparam logic [2:0] CMD_SET_EOS     = 3'd6;

    // Status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SPACE_SHORT = 3'd1;
    localparam logic [2:0] ST_NO_DATA     = 3'd2;
    localparam logic [2:0] ST_EOS         = 3'd3;
    localparam logic [2:0] ST_SPILL_SMALL = 3'd4;
    localparam logic [2:0] ST_BUSY        = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_RING_SIZE  = 1'b0;
    localparam logic CFG_SPILL_SIZE = 1'b1;

    localparam int CFG_WIDTH = 17;
    localparam int CNT_WIDTH = 17;

    typedef struct packed {
        logic [2:0]           command;
        logic [CNT_WIDTH-1:0] byte_count;
        logic                 eos_value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [15:0]          start_index;
        logic [CNT_WIDTH-1:0] copy_length;
        logic [CNT_WIDTH-1:0] occupancy;
        logic [15:0]          head_index;
        logic [15:0]          tail_index;
        logic                 stream_ended;
    } rsp_t;

endpackage

`default_nettype wire

FILE: hdl/ring_buffer_reservation_control_top.sv
`default_nettype none

// Ring buffer reservation control.
// An accepted command is held in the input stage, and its response is registered once the response register is free.
// Throughput: one command per cycle while responses are taken, set by the single state-update stage.
// Reset (rst_n low, asynchronous): ring size min(65536, MAX_RING), no spill area,
// empty buffer, no open reservations, end of stream cleared, both stages empty.
module ring_buffer_reservation_control_top
    import rbrc_pkg::*;
#(
    parameter int MAX_RING = 65536
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [CFG_WIDTH-1:0] cfg_wdata,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  wire cmd_t                 cmd_data,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output rsp_t                      rsp_data
);

    // The ring length register is at most 17 bits, so the ring can never
    // exceed 131071 bytes whatever MAX_RING is.
    localparam int RING_CAP = (MAX_RING < 131071) ? MAX_RING : 131071;
    localparam int PW       = (RING_CAP > 2) ? $clog2(RING_CAP) : 1;
    localparam int CW       = $clog2(RING_CAP + 1);
    // Working width for sums such as ring - tail + head and head + count.
    localparam int AW       = ((CW > CNT_WIDTH) ? CW : CNT_WIDTH) + 2;
    localparam int RING_RST = (RING_CAP < 65536) ? RING_CAP : 65536;

    // Configuration: the clamped ring length is stored, so no clamp sits in
    // the command path.
    logic [CW-1:0]        ring_reg;
    logic [CFG_WIDTH-1:0] spill_reg;

    // Pointer and occupancy state.
    logic [PW-1:0]        head_reg, head_next;
    logic [PW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [CNT_WIDTH-1:0] open_read_reg, open_read_next;
    logic [CNT_WIDTH-1:0] open_write_reg, open_write_next;
    logic                 eos_reg, eos_next;

    // Input stage and response stage.
    logic s1_valid_reg;
    cmd_t s1_cmd_reg;
    logic rsp_valid_reg;
    rsp_t rsp_data_reg, rsp_data_next;

    logic advance;

    // The response register is free when empty or being drained this cycle;
    // the input stage moves forward whenever the response register is free.
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign cmd_ready = !s1_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    function automatic logic [AW-1:0] amin(input logic [AW-1:0] a, input logic [AW-1:0] b);
        amin = (a < b) ? a : b;
    endfunction

    // Clamp a written ring size: zero acts as one, anything above the cap as the cap.
    logic [AW-1:0] cfg_val_w;
    logic [AW-1:0] ring_cfg_w;
    assign cfg_val_w  = AW'(cfg_wdata);
    assign ring_cfg_w = (cfg_val_w == '0) ? AW'(1) :
                        (cfg_val_w > AW'(RING_CAP)) ? AW'(RING_CAP) : cfg_val_w;

    // Zero-extended operands.
    logic [AW-1:0] h, t, f, ow, orr, ring, spill, n, half;
    assign h     = AW'(head_reg);
    assign t     = AW'(tail_reg);
    assign f     = AW'(fill_reg);
    assign ow    = AW'(open_write_reg);
    assign orr   = AW'(open_read_reg);
    assign ring  = AW'(ring_reg);
    assign spill = AW'(spill_reg);
    assign n     = AW'(s1_cmd_reg.byte_count);
    assign half  = ring >> 1;

    logic [AW-1:0] avail, d, pos, copy, start, h_new, t_new, f_new;
    logic [2:0]    status;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        open_read_next  = open_read_reg;
        open_write_next = open_write_reg;
        eos_next        = eos_reg;
        status          = ST_OK;
        start           = '0;
        copy            = '0;
        avail           = '0;
        d               = '0;
        pos             = '0;
        h_new           = h;
        t_new           = t;
        f_new           = f;

        unique case (s1_cmd_reg.command)
            CMD_BEGIN_WRITE:
            begin
                if (t > h || (t == h && f == '0))
                    avail = ring - t + amin(h, spill);
                else if (t < h)
                    avail = h - t;
                else
                    avail = '0;
                if (ow != '0)
                    status = ST_BUSY;
                else if (n > avail)
                    status = ST_SPACE_SHORT;
                else
                begin
                    open_write_next = s1_cmd_reg.byte_count;
                    start           = t;
                end
            end
            CMD_END_WRITE:
            begin
                // The tail stays below the ring and d is at most the free
                // space, so one conditional subtract wraps the pointer.
                d     = amin(amin(n, ow), ring - f);
                pos   = t + d;
                copy  = (pos > ring) ? pos - ring : '0;
                t_new = (pos >= ring) ? pos - ring : pos;
                f_new = f + d;
                tail_next       = t_new[PW-1:0];
                fill_next       = f_new[CW-1:0];
                open_write_next = '0;
            end
            CMD_BEGIN_READ:
            begin
                if (h > t)
                    avail = (spill == '0) ? ring - h + t : ring - h + amin(t, spill);
                else if (h < t)
                    avail = t - h;
                else
                    avail = (f == '0) ? '0 : n;
                pos = h + n;
                if (orr != '0)
                    status = ST_BUSY;
                else if (n > f)
                    status = eos_reg ? ST_EOS : ST_NO_DATA;
                else if (n > avail)
                    status = ST_NO_DATA;
                else if (spill != '0 && pos > ring && pos - ring > spill)
                    status = ST_SPILL_SMALL;
                else
                begin
                    if (spill != '0 && pos > ring)
                        copy = pos - ring;
                    open_read_next = s1_cmd_reg.byte_count;
                    start          = h;
                end
            end
            CMD_END_READ:
            begin
                d     = amin(amin(n, orr), f);
                pos   = h + d;
                h_new = (pos >= ring) ? pos - ring : pos;
                f_new = f - d;
                head_next      = h_new[PW-1:0];
                fill_next      = f_new[CW-1:0];
                open_read_next = '0;
            end
            CMD_CLEAR:
            begin
                if (orr != '0 || ow != '0)
                    status = ST_BUSY;
                else
                begin
                    eos_next  = 1'b0;
                    head_next = '0;
                    tail_next = '0;
                    fill_next = '0;
                end
            end
            CMD_DISCARD:
            begin
                if (orr != '0 || ow != '0)
                    status = ST_BUSY;
                else if (f > half)
                begin
                    // Drop the oldest bytes until half the ring is left.
                    d     = f - half;
                    pos   = h + d;
                    h_new = (pos >= ring) ? pos - ring : pos;
                    head_next = h_new[PW-1:0];
                    fill_next = half[CW-1:0];
                end
            end
            CMD_SET_EOS:
            begin
                eos_next = s1_cmd_reg.eos_value;
            end
            default:
            begin
                // The unused command code leaves everything as it is.
            end
        endcase
    end

    // Response fields are read from the post-command state.
    logic [AW-1:0] head_out, tail_out, fill_out;
    assign head_out = AW'(head_next);
    assign tail_out = AW'(tail_next);
    assign fill_out = AW'(fill_next);

    always_comb
    begin
        rsp_data_next.status       = status;
        rsp_data_next.start_index  = start[15:0];
        rsp_data_next.copy_length  = copy[CNT_WIDTH-1:0];
        rsp_data_next.occupancy    = fill_out[CNT_WIDTH-1:0];
        rsp_data_next.head_index   = head_out[15:0];
        rsp_data_next.tail_index   = tail_out[15:0];
        rsp_data_next.stream_ended = eos_next;
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg       <= CW'(RING_RST);
            spill_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            open_read_reg  <= '0;
            open_write_reg <= '0;
            eos_reg        <= 1'b0;
            s1_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
                s1_valid_reg <= cmd_valid;
            if (advance)
                rsp_valid_reg <= s1_valid_reg;

            if (cfg_we)
            begin
                // Any register write also empties the buffer.
                case (cfg_index)
                    CFG_RING_SIZE:  ring_reg  <= ring_cfg_w[CW-1:0];
                    CFG_SPILL_SIZE: spill_reg <= cfg_wdata;
                    default:        spill_reg <= spill_reg;
                endcase
                head_reg       <= '0;
                tail_reg       <= '0;
                fill_reg       <= '0;
                open_read_reg  <= '0;
                open_write_reg <= '0;
                eos_reg        <= 1'b0;
            end
            else if (advance && s1_valid_reg)
            begin
                head_reg       <= head_next;
                tail_reg       <= tail_next;
                fill_reg       <= fill_next;
                open_read_reg  <= open_read_next;
                open_write_reg <= open_write_next;
                eos_reg        <= eos_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
            s1_cmd_reg <= cmd_data;
        if (advance && s1_valid_reg)
            rsp_data_reg <= rsp_data_next;
    end

endmodule

`default_nettype wire
